@@ src/rmq_pkg.sv @@
// Shared types, widths and helper functions for the rotation matrix to quaternion unit.
package rmq_pkg;

   // Number format of the matrix entries and quaternion components.
   localparam int DATA_W = 16;
   localparam int FRAC_W = 14;

   // Radicand, pair sums and square root widths.
   localparam int RAD_W  = DATA_W + 3;
   localparam int PAIR_W = DATA_W + 1;
   localparam int SQ_W   = ((RAD_W + FRAC_W + 1) / 2) * 2;
   localparam int ROOT_W = SQ_W / 2;
   localparam int RQ_W   = ROOT_W + 1;
   localparam int DEN_W  = RQ_W + 1;

   // Division widths.
   localparam int NUM_W  = PAIR_W + FRAC_W;
   localparam int QUO_W  = NUM_W + 1;

   typedef enum logic [1:0] {
      BR_X     = 2'd0,
      BR_Y     = 2'd1,
      BR_Z     = 2'd2,
      BR_TRACE = 2'd3
   } branch_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] r0c0;
      logic signed [DATA_W-1:0] r0c1;
      logic signed [DATA_W-1:0] r0c2;
      logic signed [DATA_W-1:0] r1c0;
      logic signed [DATA_W-1:0] r1c1;
      logic signed [DATA_W-1:0] r1c2;
      logic signed [DATA_W-1:0] r2c0;
      logic signed [DATA_W-1:0] r2c1;
      logic signed [DATA_W-1:0] r2c2;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] quat_x;
      logic signed [DATA_W-1:0] quat_y;
      logic signed [DATA_W-1:0] quat_z;
      logic signed [DATA_W-1:0] quat_w;
      logic                     degenerate;
   } rsp_type;

   // Sideband carried alongside the square root.
   typedef struct packed {
      logic signed [PAIR_W-1:0] p0;
      logic signed [PAIR_W-1:0] p1;
      logic signed [PAIR_W-1:0] p2;
      branch_type               branch;
      logic                     degen;
   } sq_side_type;

   // Classified beat handed from the front part to the back part.
   typedef struct packed {
      logic [RAD_W-1:0] rad;
      sq_side_type      side;
   } front_item_type;

   // Sideband carried alongside the first divider lane.
   typedef struct packed {
      logic             neg;
      logic [RQ_W-1:0]  main;
      branch_type       branch;
      logic             degen;
   } div_side_type;

   // Saturate a magnitude with sign to the signed component range.
   function automatic logic [DATA_W-1:0] sat_quo(input logic [QUO_W-1:0] q, input logic neg);
      logic [QUO_W-1:0] lim;
      logic [QUO_W-1:0] negq;
      lim  = neg ? (QUO_W'(1) << (DATA_W - 1)) : ((QUO_W'(1) << (DATA_W - 1)) - QUO_W'(1));
      negq = ~q + QUO_W'(1);
      if (q > lim) begin
         sat_quo = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sat_quo = neg ? negq[DATA_W-1:0] : q[DATA_W-1:0];
      end
   endfunction

endpackage

@@ src/rmq_front.sv @@
// Front part: picks the branch, forms the radicand and the three pair sums.
module rmq_front import rmq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  req_type        in_item,
   output logic           out_valid,
   output front_item_type out_item
);

   logic           valid_ff, valid_in;
   front_item_type item_ff, item_in;

   logic signed [RAD_W-1:0]  d0, d1, d2, one, trace, rad;
   logic signed [PAIR_W-1:0] p0, p1, p2;
   branch_type               branch;

   // Classify the matrix and build the branch quantities.
   always_comb begin
      d0    = RAD_W'(in_item.r0c0);
      d1    = RAD_W'(in_item.r1c1);
      d2    = RAD_W'(in_item.r2c2);
      one   = RAD_W'(1) << FRAC_W;
      trace = d0 + d1 + d2;
      priority if (trace > 0) begin
         branch = BR_TRACE;
         rad    = one + trace;
         p0 = PAIR_W'(in_item.r1c2) - PAIR_W'(in_item.r2c1);
         p1 = PAIR_W'(in_item.r2c0) - PAIR_W'(in_item.r0c2);
         p2 = PAIR_W'(in_item.r0c1) - PAIR_W'(in_item.r1c0);
      end else if (in_item.r0c0 > in_item.r1c1 && in_item.r0c0 > in_item.r2c2) begin
         branch = BR_X;
         rad    = one + d0 - d1 - d2;
         p0 = PAIR_W'(in_item.r0c1) + PAIR_W'(in_item.r1c0);
         p1 = PAIR_W'(in_item.r0c2) + PAIR_W'(in_item.r2c0);
         p2 = PAIR_W'(in_item.r1c2) - PAIR_W'(in_item.r2c1);
      end else if (in_item.r1c1 > in_item.r2c2) begin
         branch = BR_Y;
         rad    = one + d1 - d0 - d2;
         p0 = PAIR_W'(in_item.r1c0) + PAIR_W'(in_item.r0c1);
         p1 = PAIR_W'(in_item.r2c1) + PAIR_W'(in_item.r1c2);
         p2 = PAIR_W'(in_item.r2c0) - PAIR_W'(in_item.r0c2);
      end else begin
         branch = BR_Z;
         rad    = one + d2 - d0 - d1;
         p0 = PAIR_W'(in_item.r2c0) + PAIR_W'(in_item.r0c2);
         p1 = PAIR_W'(in_item.r2c1) + PAIR_W'(in_item.r1c2);
         p2 = PAIR_W'(in_item.r0c1) - PAIR_W'(in_item.r1c0);
      end
      item_in.rad         = rad;
      item_in.side.p0     = p0;
      item_in.side.p1     = p1;
      item_in.side.p2     = p2;
      item_in.side.branch = branch;
      item_in.side.degen  = (rad <= 0);
      valid_in            = in_valid;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ src/rmq_queue.sv @@
// Two-entry queue between the front part and the back part.
module rmq_queue import rmq_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  front_item_type push_item,
   input  logic           pop,
   output logic           full,
   output logic           out_valid,
   output front_item_type out_item
);

   front_item_type mem_ff [0:1];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push, do_pop;

   // Pointer and fill count update.
   always_comb begin
      do_push   = push && (count_ff != 2'd2);
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];

endmodule

@@ src/rmq_sqrt.sv @@
// Pipelined rounded integer square root, one root bit per stage.
module rmq_sqrt import rmq_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [SQ_W-1:0]   in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RQ_W-1:0]   out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [0:ROOT_W];
   logic [SQ_W-1:0]   rad_ff   [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff  [0:ROOT_W];
   logic [ROOT_W+1:0] rem_ff   [0:ROOT_W];
   logic [SIDE_W-1:0] side_ff  [0:ROOT_W];

   logic              oval_ff;
   logic [RQ_W-1:0]   oroot_ff, oroot_in;
   logic [SIDE_W-1:0] oside_ff;

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff[0]  <= in_rad;
      root_ff[0] <= '0;
      rem_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   // One root bit per stage: bring down two radicand bits and try a subtract.
   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      logic [ROOT_W+1:0] rem_sh, trial, rem_in;
      logic              take;

      always_comb begin
         rem_sh = {rem_ff[s][ROOT_W-1:0], rad_ff[s][SQ_W-1 -: 2]};
         trial  = {root_ff[s], 2'b01};
         take   = (rem_sh >= trial);
         rem_in = take ? (rem_sh - trial) : rem_sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         rad_ff[s+1]  <= rad_ff[s] << 2;
         root_ff[s+1] <= {root_ff[s][ROOT_W-2:0], take};
         rem_ff[s+1]  <= rem_in;
         side_ff[s+1] <= side_ff[s];
      end
   end

   // Round to nearest: step up when the remainder exceeds the floor root.
   always_comb begin
      oroot_in = {1'b0, root_ff[ROOT_W]}
               + RQ_W'(rem_ff[ROOT_W] > {2'b00, root_ff[ROOT_W]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oval_ff <= 1'b0;
      end else begin
         oval_ff <= valid_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      oroot_ff <= oroot_in;
      oside_ff <= side_ff[ROOT_W];
   end

   assign out_valid = oval_ff;
   assign out_root  = oroot_ff;
   assign out_side  = oside_ff;

endmodule

@@ src/rmq_div.sv @@
// Pipelined restoring divider with round half up, one quotient bit per stage.
module rmq_div import rmq_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [0:NUM_W];
   logic [NUM_W-1:0]  num_ff   [0:NUM_W];
   logic [DEN_W-1:0]  den_ff   [0:NUM_W];
   logic [NUM_W-1:0]  quo_ff   [0:NUM_W];
   logic [DEN_W-1:0]  rem_ff   [0:NUM_W];
   logic [SIDE_W-1:0] side_ff  [0:NUM_W];

   logic              oval_ff;
   logic [QUO_W-1:0]  oquo_ff, oquo_in;
   logic [SIDE_W-1:0] oside_ff;

   // Input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      quo_ff[0]  <= '0;
      rem_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   // One quotient bit per stage.
   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [DEN_W:0]   rem_sh, diff;
      logic [DEN_W-1:0] rem_in;
      logic             take;

      always_comb begin
         rem_sh = {rem_ff[s], num_ff[s][NUM_W-1]};
         diff   = rem_sh - {1'b0, den_ff[s]};
         take   = (rem_sh >= {1'b0, den_ff[s]});
         rem_in = take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         num_ff[s+1]  <= num_ff[s] << 1;
         den_ff[s+1]  <= den_ff[s];
         quo_ff[s+1]  <= {quo_ff[s][NUM_W-2:0], take};
         rem_ff[s+1]  <= rem_in;
         side_ff[s+1] <= side_ff[s];
      end
   end

   // Round: step up when twice the remainder reaches the divisor.
   always_comb begin
      oquo_in = {1'b0, quo_ff[NUM_W]}
              + QUO_W'({rem_ff[NUM_W], 1'b0} >= {1'b0, den_ff[NUM_W]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oval_ff <= 1'b0;
      end else begin
         oval_ff <= valid_ff[NUM_W];
      end
   end

   always_ff @(posedge clock) begin
      oquo_ff  <= oquo_in;
      oside_ff <= side_ff[NUM_W];
   end

   assign out_valid = oval_ff;
   assign out_quo   = oquo_ff;
   assign out_side  = oside_ff;

endmodule

@@ src/rotation_matrix_to_quaternion_unit.sv @@
// Throughput: one matrix per cycle, set by the fully pipelined square root and dividers.
// busy rises only if the front/back queue fills, which the non-stalling back part prevents.
// The receiver cannot stall: each result is shown on rsp_item for one cycle with rsp_valid.
// Reset is synchronous and active high; it clears all valid bits and the queue pointers.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   logic           fr_valid, q_full, q_valid;
   front_item_type fr_item, q_item;

   logic              sq_valid;
   logic [RQ_W-1:0]   sq_root;
   logic [$bits(sq_side_type)-1:0] sq_side_bits;
   sq_side_type       sq_side;

   logic [DEN_W-1:0]  den;
   logic [RQ_W:0]     main_sum;
   div_side_type      dv_side_in;
   logic [PAIR_W-1:0] mag0, mag1, mag2;
   logic [NUM_W-1:0]  num0, num1, num2;

   logic              dv_valid0, dv_valid1, dv_valid2;
   logic [QUO_W-1:0]  quo0, quo1, quo2;
   logic [$bits(div_side_type)-1:0] dv_side_bits;
   div_side_type      dv_side;
   logic              neg1, neg2;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [DATA_W-1:0] o0, o1, o2, mainc;

   // Front part: classify each accepted beat.
   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_item   (req_item),
      .out_valid (fr_valid),
      .out_item  (fr_item)
   );

   rmq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_item (fr_item),
      .pop       (q_valid),
      .full      (q_full),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   assign busy = q_full;

   // Back part: square root of the radicand scaled by the fraction bits.
   rmq_sqrt #(.SIDE_W($bits(sq_side_type))) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_rad    (q_item.side.degen ? '0 : SQ_W'({q_item.rad, {FRAC_W{1'b0}}})),
      .in_side   (q_item.side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_bits)
   );

   assign sq_side = sq_side_type'(sq_side_bits);

   // Divisor, main component and pair magnitudes.
   always_comb begin
      den               = {sq_root, 1'b0};
      main_sum          = {1'b0, sq_root} + (RQ_W+1)'(1);
      mag0              = sq_side.p0[PAIR_W-1] ? -sq_side.p0 : sq_side.p0;
      mag1              = sq_side.p1[PAIR_W-1] ? -sq_side.p1 : sq_side.p1;
      mag2              = sq_side.p2[PAIR_W-1] ? -sq_side.p2 : sq_side.p2;
      num0              = {mag0, {FRAC_W{1'b0}}};
      num1              = {mag1, {FRAC_W{1'b0}}};
      num2              = {mag2, {FRAC_W{1'b0}}};
      dv_side_in.neg    = sq_side.p0[PAIR_W-1];
      dv_side_in.main   = main_sum[RQ_W:1];
      dv_side_in.branch = sq_side.branch;
      dv_side_in.degen  = sq_side.degen;
   end

   rmq_div #(.SIDE_W($bits(div_side_type))) u_div0 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_num    (num0),
      .in_den    (den),
      .in_side   (dv_side_in),
      .out_valid (dv_valid0),
      .out_quo   (quo0),
      .out_side  (dv_side_bits)
   );

   rmq_div #(.SIDE_W(1)) u_div1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_num    (num1),
      .in_den    (den),
      .in_side   (sq_side.p1[PAIR_W-1]),
      .out_valid (dv_valid1),
      .out_quo   (quo1),
      .out_side  (neg1)
   );

   rmq_div #(.SIDE_W(1)) u_div2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_num    (num2),
      .in_den    (den),
      .in_side   (sq_side.p2[PAIR_W-1]),
      .out_valid (dv_valid2),
      .out_quo   (quo2),
      .out_side  (neg2)
   );

   assign dv_side = div_side_type'(dv_side_bits);

   // Saturate and place the components by branch.
   always_comb begin
      o0           = sat_quo(quo0, dv_side.neg);
      o1           = sat_quo(quo1, neg1);
      o2           = sat_quo(quo2, neg2);
      mainc        = sat_quo(QUO_W'(dv_side.main), 1'b0);
      rsp_valid_in = dv_valid0 && dv_valid1 && dv_valid2;
      unique case (dv_side.branch)
         BR_TRACE: begin
            rsp_in.quat_x = o0;
            rsp_in.quat_y = o1;
            rsp_in.quat_z = o2;
            rsp_in.quat_w = mainc;
         end
         BR_X: begin
            rsp_in.quat_x = mainc;
            rsp_in.quat_y = o0;
            rsp_in.quat_z = o1;
            rsp_in.quat_w = o2;
         end
         BR_Y: begin
            rsp_in.quat_x = o0;
            rsp_in.quat_y = mainc;
            rsp_in.quat_z = o1;
            rsp_in.quat_w = o2;
         end
         default: begin
            rsp_in.quat_x = o0;
            rsp_in.quat_y = o1;
            rsp_in.quat_z = mainc;
            rsp_in.quat_w = o2;
         end
      endcase
      if (dv_side.degen) begin
         rsp_in.quat_x = '0;
         rsp_in.quat_y = '0;
         rsp_in.quat_z = '0;
         rsp_in.quat_w = '0;
      end
      rsp_in.degenerate = dv_side.degen;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ tb/rotation_matrix_to_quaternion_unit_tb.sv @@
// Self-checking testbench for the rotation matrix to quaternion unit.
module rotation_matrix_to_quaternion_unit_tb;
   import rmq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY      = 54;
   localparam int RANDOM_BEATS = 1500;
   localparam int WATCHDOG_MAX = 2000;
   localparam int ONE          = 1 << FRAC_W;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   rsp_type expected_quats[$];
   int      error_count;
   int      idle_cycles;
   bit      stim_done;
   bit      timed_out;

   // One directed row: the matrix, and optionally a typed-in expected result.
   typedef struct {
      req_type m;
      bit      has_exp;
      rsp_type exp_q;
   } directed_row_type;

   directed_row_type directed_rows[$];

   rotation_matrix_to_quaternion_unit uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Rounded integer square root.
   function automatic longint unsigned isqrt_round(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      if (n > res) res++;
      return res;
   endfunction

   // Pair value scaled by one and divided by the denominator, ties away from zero.
   function automatic longint scaled_quotient(input longint p, input longint unsigned d);
      longint unsigned mag;
      longint unsigned num;
      longint unsigned q;
      mag = (p < 0) ? longint'(-p) : longint'(p);
      num = mag << FRAC_W;
      q   = num / d;
      if ((num % d) * 2 >= d) q++;
      return (p < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [DATA_W-1:0] clamp_component(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (DATA_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[DATA_W-1:0];
   endfunction

   // Shepperd branch choice and component computation.
   function automatic rsp_type predict_quaternion(input req_type m);
      longint     a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint     rad, p0, p1, p2;
      longint     comps[4];
      longint     others[3];
      longint unsigned rq;
      branch_type br;
      int         k;
      rsp_type    q;
      a00 = m.r0c0; a01 = m.r0c1; a02 = m.r0c2;
      a10 = m.r1c0; a11 = m.r1c1; a12 = m.r1c2;
      a20 = m.r2c0; a21 = m.r2c1; a22 = m.r2c2;
      if (a00 + a11 + a22 > 0) begin
         br  = BR_TRACE;
         rad = ONE + a00 + a11 + a22;
         p0 = a12 - a21; p1 = a20 - a02; p2 = a01 - a10;
      end else if (a00 > a11 && a00 > a22) begin
         br  = BR_X;
         rad = ONE + a00 - a11 - a22;
         p0 = a01 + a10; p1 = a02 + a20; p2 = a12 - a21;
      end else if (a11 > a22) begin
         br  = BR_Y;
         rad = ONE + a11 - a00 - a22;
         p0 = a10 + a01; p1 = a21 + a12; p2 = a20 - a02;
      end else begin
         br  = BR_Z;
         rad = ONE + a22 - a00 - a11;
         p0 = a20 + a02; p1 = a21 + a12; p2 = a01 - a10;
      end
      q = '0;
      if (rad <= 0) begin
         q.degenerate = 1'b1;
         return q;
      end
      rq        = isqrt_round(longint'(rad) << FRAC_W);
      others[0] = scaled_quotient(p0, rq * 2);
      others[1] = scaled_quotient(p1, rq * 2);
      others[2] = scaled_quotient(p2, rq * 2);
      k = 0;
      for (int i = 0; i < 4; i++) begin
         if (i == int'(br)) begin
            comps[i] = longint'((rq + 1) >> 1);
         end else begin
            comps[i] = others[k];
            k++;
         end
      end
      q.quat_x = clamp_component(comps[0]);
      q.quat_y = clamp_component(comps[1]);
      q.quat_z = clamp_component(comps[2]);
      q.quat_w = clamp_component(comps[3]);
      return q;
   endfunction

   function automatic req_type make_matrix(input int a00, a01, a02, a10, a11, a12,
                                           a20, a21, a22);
      req_type m;
      m.r0c0 = DATA_W'(a00); m.r0c1 = DATA_W'(a01); m.r0c2 = DATA_W'(a02);
      m.r1c0 = DATA_W'(a10); m.r1c1 = DATA_W'(a11); m.r1c2 = DATA_W'(a12);
      m.r2c0 = DATA_W'(a20); m.r2c1 = DATA_W'(a21); m.r2c2 = DATA_W'(a22);
      return m;
   endfunction

   function automatic void add_row(input req_type m, input bit has_exp, input rsp_type e);
      directed_row_type row;
      row.m       = m;
      row.has_exp = has_exp;
      row.exp_q   = e;
      directed_rows.push_back(row);
   endfunction

   function automatic rsp_type quat_of(input int x, y, z, w, input bit dg);
      rsp_type q;
      q.quat_x = DATA_W'(x); q.quat_y = DATA_W'(y);
      q.quat_z = DATA_W'(z); q.quat_w = DATA_W'(w);
      q.degenerate = dg;
      return q;
   endfunction

   // Random rotation-like matrix: mostly near-valid entries, sometimes raw noise.
   function automatic req_type random_matrix();
      req_type      m;
      int           mode;
      int           d[3];
      logic [159:0] noise;
      mode  = $urandom_range(0, 9);
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      m     = noise[$bits(req_type)-1:0];
      if (mode < 7) begin
         for (int i = 0; i < 3; i++) d[i] = int'($urandom_range(0, 2 * ONE)) - ONE;
         m.r0c0 = DATA_W'(d[0]); m.r1c1 = DATA_W'(d[1]); m.r2c2 = DATA_W'(d[2]);
         m.r0c1 = DATA_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
         m.r0c2 = DATA_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
         m.r1c0 = DATA_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
         m.r1c2 = DATA_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
         m.r2c0 = DATA_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
         m.r2c1 = DATA_W'(int'($urandom_range(0, 2 * ONE)) - ONE);
         if (mode == 6) m.r1c1 = m.r0c0;
      end
      return m;
   endfunction

   // Drive one beat at the falling edge and hold it until accepted.
   // busy only changes at a rising edge, so its value at the falling edge
   // decides whether the next rising edge accepts the beat.
   task automatic send_matrix(input req_type m, input bit has_exp, input rsp_type e);
      rsp_type p;
      p = predict_quaternion(m);
      if (has_exp && p !== e) begin
         $error("directed row predictor disagrees: expected %h, predicted %h", e, p);
         error_count++;
      end
      start    <= 1'b1;
      req_item <= m;
      #1;
      while (busy) @(negedge clock);
      @(posedge clock);
      expected_quats.push_back(has_exp ? e : p);
      @(negedge clock);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_quats.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_item);
            error_count++;
         end else begin
            rsp_type e;
            e = expected_quats.pop_front();
            if (rsp_item.quat_x !== e.quat_x) begin
               $error("quat_x expected %0d actual %0d", e.quat_x, rsp_item.quat_x);
               error_count++;
            end
            if (rsp_item.quat_y !== e.quat_y) begin
               $error("quat_y expected %0d actual %0d", e.quat_y, rsp_item.quat_y);
               error_count++;
            end
            if (rsp_item.quat_z !== e.quat_z) begin
               $error("quat_z expected %0d actual %0d", e.quat_z, rsp_item.quat_z);
               error_count++;
            end
            if (rsp_item.quat_w !== e.quat_w) begin
               $error("quat_w expected %0d actual %0d", e.quat_w, rsp_item.quat_w);
               error_count++;
            end
            if (rsp_item.degenerate !== e.degenerate) begin
               $error("degenerate expected %0b actual %0b", e.degenerate,
                      rsp_item.degenerate);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted beat on either side.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (stim_done && expected_quats.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX && !timed_out) begin
         timed_out = 1'b1;
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      stim_done   = 1'b0;
      timed_out   = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_item    = '0;

      // Directed table: identity, half-turns, ties, extremes.
      add_row(make_matrix(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
              quat_of(0, 0, 0, ONE, 0));
      add_row(make_matrix(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE), 1,
              quat_of(ONE, 0, 0, 0, 0));
      add_row(make_matrix(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE), 1,
              quat_of(0, ONE, 0, 0, 0));
      add_row(make_matrix(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE), 1,
              quat_of(0, 0, ONE, 0, 0));
      add_row(make_matrix(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE), 0, '0);
      add_row(make_matrix(0, 0, -ONE, 0, ONE, 0, ONE, 0, 0), 0, '0);
      add_row(make_matrix(ONE, 0, 0, 0, 0, ONE, 0, -ONE, 0), 0, '0);
      // Diagonal ties fall through to the later branch.
      add_row(make_matrix(-ONE, 100, 200, 300, -ONE, 400, 500, 600, -ONE), 0, '0);
      add_row(make_matrix(0, 1000, 0, 1000, 0, 0, 0, 0, -ONE), 0, '0);
      add_row(make_matrix(0, 0, 0, 0, -ONE, 0, 0, 0, 0), 0, '0);
      add_row(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
      // Extreme diagonals with a large radicand.
      add_row(make_matrix(-32768, 5, 6, 7, -32768, 8, 9, 10, -32768), 0, '0);
      add_row(make_matrix(-ONE, 1, 1, 1, 32767, 1, 1, 1, 32767), 0, '0);
      // Saturating components and all-ones / extreme off-diagonals.
      add_row(make_matrix(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767,
                          32767), 0, '0);
      add_row(make_matrix(32767, -32768, -32768, -32768, 32767, -32768, -32768,
                          -32768, 32767), 0, '0);
      add_row(make_matrix(32767, 32767, -32768, -32768, -32768, 32767, 32767,
                          -32768, -32768), 0, '0);
      add_row(make_matrix(1, -1, -1, -1, 0, -1, -1, -1, 0), 0, '0);
      add_row(make_matrix(-32768, -1, -1, -1, -32767, -1, -1, -1, 32767), 0, '0);
      add_row(make_matrix(-16000, 32767, -32768, 32767, -16000, -32768, 12345,
                          -12345, -16000), 0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_matrix(directed_rows[i].m, directed_rows[i].has_exp, directed_rows[i].exp_q);

      // Sender pause until the pipeline has drained.
      start <= 1'b0;
      while (expected_quats.size() != 0) @(negedge clock);

      // Random part with sender idle bursts, then a back-to-back tail.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n < RANDOM_BEATS - 200 && $urandom_range(0, 3) == 0) idle_burst();
         send_matrix(random_matrix(), 0, '0);
      end
      start     <= 1'b0;
      stim_done  = 1'b1;

      while (expected_quats.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
